// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// File: src/apsd_pkg.sv
// ----------------------------------------------------------------------------
// Allpass stereo decorrelator package
// Register map, reset values, Q15 constants and the controller interface.
// ----------------------------------------------------------------------------
package apsd_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_LEN_W  = 9;
  localparam int NUM_LANES  = 2;

  localparam int Q15_FRAC = 15;
  localparam int Q15_ONE  = 32768;
  localparam int Q15_HALF = 16384;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIX_WIDTH       = 3'd0,
    REG_ALLPASS_COEFF   = 3'd1,
    REG_STEREO_MODE     = 3'd2,
    REG_LEFT_DELAY_LEN  = 3'd3,
    REG_RIGHT_DELAY_LEN = 3'd4
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0]        MIX_WIDTH_RST = 16'd0;
  localparam logic signed [CFG_DATA_W-1:0] COEFF_RST     = 16'sd16384;
  localparam logic [CFG_LEN_W-1:0]         LEFT_LEN_RST  = 9'd89;
  localparam logic [CFG_LEN_W-1:0]         RIGHT_LEN_RST = 9'd97;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]        mix_width;
    logic signed [CFG_DATA_W-1:0] allpass_coeff;
    logic                         stereo_mode;
    logic [CFG_LEN_W-1:0]         left_delay_len;
    logic [CFG_LEN_W-1:0]         right_delay_len;
  } apsd_cfg_t;

  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic load;
    logic mul_a;
    logic lane;
    logic mul_b;
    logic write;
    logic finish;
  } apsd_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } apsd_sts_t;

endpackage

// File: src/apsd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apsd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/apsd_ctrl.sv
// ----------------------------------------------------------------------------
// Allpass decorrelator controller
// Sequences the clearing pass and the steps of one frame through the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apsd_ctrl
  import apsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      clr_req,
  input  logic      s_tvalid,
  output logic      s_tready,
  output apsd_cmd_t cmd,
  input  apsd_sts_t sts
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_MULA   = 7'b0000100,
    ST_LANE   = 7'b0001000,
    ST_MULB   = 7'b0010000,
    ST_WRITE  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE) && !clr_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    if (clr_req) begin
      cmd.clear_start = 1'b1;
      state_next      = ST_CLEAR;
    end else begin
      case (state)
        ST_CLEAR: begin
          cmd.clear_step = 1'b1;
          if (sts.clear_last) begin
            state_next = ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd.load   = 1'b1;
            state_next = ST_MULA;
          end
        end
        ST_MULA: begin
          cmd.mul_a  = 1'b1;
          state_next = ST_LANE;
        end
        ST_LANE: begin
          cmd.lane   = 1'b1;
          state_next = ST_MULB;
        end
        ST_MULB: begin
          cmd.mul_b  = 1'b1;
          state_next = ST_WRITE;
        end
        ST_WRITE: begin
          cmd.write  = 1'b1;
          state_next = ST_FINISH;
        end
        ST_FINISH: begin
          if (sts.out_free) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
        default: begin
          state_next = ST_CLEAR;
        end
      endcase
    end
  end

  `ASSERT_AT(a_accept_starts_frame, s_tvalid && s_tready |=> state == ST_MULA, "accepted request did not start a frame")
  `ASSERT_AT(a_clear_on_request, clr_req |=> state == ST_CLEAR, "delay length write did not start clearing")
  `ASSERT_AT(a_clear_done, state == ST_CLEAR && sts.clear_last && !clr_req |=> state == ST_IDLE, "clearing pass did not end")

endmodule

// File: src/apsd_dp.sv
// ----------------------------------------------------------------------------
// Allpass decorrelator datapath
// Mid/side split, two allpass delay lanes with wet/dry mix, and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apsd_dp
  import apsd_pkg::*;
#(
  parameter int MAX_DELAY   = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  apsd_cfg_t                     cfg,
  input  apsd_cmd_t                     cmd,
  output apsd_sts_t                     sts,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);

  localparam int SB     = SAMPLE_BITS;
  localparam int ST     = SAMPLE_BITS + 4;
  localparam int PTR_W  = $clog2(MAX_DELAY);
  localparam int LEN_W  = (CFG_LEN_W > $clog2(MAX_DELAY + 1)) ? CFG_LEN_W
                                                               : $clog2(MAX_DELAY + 1);
  localparam int PX_W   = SB + CFG_DATA_W;
  localparam int MX_W   = SB + CFG_DATA_W + 1;
  localparam int PY_W   = ST + CFG_DATA_W;
  localparam int MY_W   = ST + CFG_DATA_W + 1;
  localparam int SUM_W  = ST + CFG_DATA_W + 2;
  localparam int LANE_W = SUM_W + 1 - Q15_FRAC;
  localparam int OUT_W  = LANE_W + 1;

  localparam logic signed [ST-1:0] ST_MAX = {1'b0, {(ST - 1){1'b1}}};
  localparam logic signed [ST-1:0] ST_MIN = {1'b1, {(ST - 1){1'b0}}};
  localparam logic signed [SB-1:0] SB_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic signed [SB-1:0] SB_MIN = {1'b1, {(SB - 1){1'b0}}};

  logic signed [CFG_DATA_W-1:0] coeff;
  logic [CFG_DATA_W-1:0]        w_eff;
  logic signed [CFG_DATA_W:0]   w_wet;
  logic signed [CFG_DATA_W:0]   w_dry;

  logic signed [SB:0]   lr_sum;
  logic signed [SB:0]   lr_diff;
  logic signed [SB-1:0] x_r;
  logic signed [SB-1:0] mid_r;

  logic signed [PX_W-1:0] pgx;
  logic signed [MX_W-1:0] pxw;
  logic signed [PX_W:0]   tgx;
  logic signed [SB+1:0]   rgx;

  logic [PTR_W-1:0] sweep;

  logic [CFG_LEN_W-1:0]    len_cfg [NUM_LANES];
  logic [LEN_W-1:0]        len_eff [NUM_LANES];
  logic                    lane_on [NUM_LANES];
  logic [PTR_W-1:0]        ptr     [NUM_LANES];
  logic [LEN_W-1:0]        ptr_inc [NUM_LANES];
  logic [ST-1:0]           rd_d    [NUM_LANES];
  logic                    ram_we  [NUM_LANES];
  logic [PTR_W-1:0]        ram_wa  [NUM_LANES];
  logic [ST-1:0]           ram_wd  [NUM_LANES];
  logic signed [ST:0]      dmy     [NUM_LANES];
  logic signed [ST-1:0]    y_next  [NUM_LANES];
  logic signed [ST-1:0]    y_q     [NUM_LANES];
  logic signed [PY_W-1:0]  pgy     [NUM_LANES];
  logic signed [MY_W-1:0]  pyw     [NUM_LANES];
  logic signed [PY_W:0]    tgy     [NUM_LANES];
  logic signed [ST+2:0]    wsum    [NUM_LANES];
  logic signed [ST-1:0]    st_val  [NUM_LANES];
  logic signed [SUM_W-1:0] msum    [NUM_LANES];
  logic signed [SUM_W:0]   tmix    [NUM_LANES];
  logic signed [LANE_W-1:0] lane_q [NUM_LANES];

  logic signed [OUT_W-1:0] ol_sum;
  logic signed [OUT_W-1:0] or_sum;
  logic signed [SB-1:0]    ol_sat;
  logic signed [SB-1:0]    or_sat;

  assign coeff = cfg.allpass_coeff;
  assign w_eff = (cfg.mix_width > CFG_DATA_W'(Q15_ONE)) ? CFG_DATA_W'(Q15_ONE) : cfg.mix_width;
  assign w_wet = $signed({1'b0, w_eff});
  assign w_dry = $signed((CFG_DATA_W + 1)'(Q15_ONE) - {1'b0, w_eff});

  assign lr_sum  = (SB + 1)'(left_sample) + (SB + 1)'(right_sample);
  assign lr_diff = (SB + 1)'(left_sample) - (SB + 1)'(right_sample);

  assign tgx = (PX_W + 1)'(pgx) + (PX_W + 1)'(Q15_HALF);
  assign rgx = tgx[PX_W:Q15_FRAC];

  assign len_cfg[0] = cfg.left_delay_len;
  assign len_cfg[1] = cfg.right_delay_len;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      len_eff[i] = (LEN_W'(len_cfg[i]) > LEN_W'(MAX_DELAY)) ? LEN_W'(MAX_DELAY)
                                                            : LEN_W'(len_cfg[i]);
      lane_on[i] = (len_cfg[i] != '0);
      ptr_inc[i] = LEN_W'(ptr[i]) + LEN_W'(1);

      dmy[i] = (ST + 1)'($signed(rd_d[i])) - (ST + 1)'(rgx);
      if (dmy[i][ST] == dmy[i][ST-1]) begin
        y_next[i] = dmy[i][ST-1:0];
      end else begin
        y_next[i] = dmy[i][ST] ? ST_MIN : ST_MAX;
      end
      if (!lane_on[i]) begin
        y_next[i] = ST'(x_r);
      end

      tgy[i]  = (PY_W + 1)'(pgy[i]) + (PY_W + 1)'(Q15_HALF);
      wsum[i] = (ST + 3)'(x_r) + (ST + 3)'($signed(tgy[i][PY_W:Q15_FRAC]));
      if ((&wsum[i][ST+2:ST-1]) || !(|wsum[i][ST+2:ST-1])) begin
        st_val[i] = wsum[i][ST-1:0];
      end else begin
        st_val[i] = wsum[i][ST+2] ? ST_MIN : ST_MAX;
      end

      msum[i] = SUM_W'(pxw) + SUM_W'(pyw[i]);
      tmix[i] = (SUM_W + 1)'(msum[i]) + (SUM_W + 1)'(Q15_HALF);

      ram_we[i] = cmd.clear_step || (cmd.write && lane_on[i]);
      ram_wa[i] = cmd.clear_step ? sweep : ptr[i];
      ram_wd[i] = cmd.clear_step ? '0 : st_val[i];
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_store
    apsd_ram #(
      .WIDTH (ST),
      .DEPTH (MAX_DELAY)
    ) u_store (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_wa[g]),
      .wdata (ram_wd[g]),
      .re    (cmd.load),
      .raddr (ptr[g]),
      .rdata (rd_d[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        ptr[i] <= '0;
      end
    end else begin
      if (cmd.clear_start) begin
        sweep <= '0;
      end else if (cmd.clear_step) begin
        sweep <= sweep + PTR_W'(1);
      end
      for (int i = 0; i < NUM_LANES; i++) begin
        if (cmd.clear_start) begin
          ptr[i] <= '0;
        end else if (cmd.write && lane_on[i]) begin
          ptr[i] <= (ptr_inc[i] == len_eff[i]) ? '0 : ptr_inc[i][PTR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= cfg.stereo_mode ? lr_diff[SB:1] : left_sample;
      mid_r <= lr_sum[SB:1];
    end
    if (cmd.mul_a) begin
      pgx <= coeff * x_r;
      pxw <= x_r * w_dry;
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      if (cmd.lane) begin
        y_q[i] <= y_next[i];
      end
      if (cmd.mul_b) begin
        pgy[i] <= coeff * y_q[i];
        pyw[i] <= y_q[i] * w_wet;
      end
      if (cmd.write) begin
        lane_q[i] <= tmix[i][SUM_W:Q15_FRAC];
      end
    end
  end

  always_comb begin
    if (cfg.stereo_mode) begin
      ol_sum = OUT_W'(mid_r) + OUT_W'(lane_q[0]);
      or_sum = OUT_W'(mid_r) - OUT_W'(lane_q[1]);
    end else begin
      ol_sum = OUT_W'(lane_q[0]);
      or_sum = OUT_W'(lane_q[1]);
    end
    if ((&ol_sum[OUT_W-1:SB-1]) || !(|ol_sum[OUT_W-1:SB-1])) begin
      ol_sat = ol_sum[SB-1:0];
    end else begin
      ol_sat = ol_sum[OUT_W-1] ? SB_MIN : SB_MAX;
    end
    if ((&or_sum[OUT_W-1:SB-1]) || !(|or_sum[OUT_W-1:SB-1])) begin
      or_sat = or_sum[SB-1:0];
    end else begin
      or_sat = or_sum[OUT_W-1] ? SB_MIN : SB_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_left  <= ol_sat;
      out_right <= or_sat;
    end
  end

  assign sts.clear_last = (sweep == PTR_W'(MAX_DELAY - 1));
  assign sts.out_free   = !m_tvalid || m_tready;

  `ASSERT_NEVER(a_left_ptr_range, lane_on[0] && (LEN_W'(ptr[0]) >= len_eff[0]), "left pointer out of range")
  `ASSERT_NEVER(a_right_ptr_range, lane_on[1] && (LEN_W'(ptr[1]) >= len_eff[1]), "right pointer out of range")
  `ASSERT_AT(a_result_from_finish, $rose(m_tvalid) |-> $past(cmd.finish), "result appeared without a finished frame")

endmodule

// File: src/allpass_stereo_decorrelator.sv
// ----------------------------------------------------------------------------
// Allpass stereo decorrelator
// Accepts a request only when idle; the frame then runs the dependent multiply, round and
// saturate steps of each allpass lane, and finish waits for the output register to be free.
// Reset, and each delay length write, runs a clearing pass over all MAX_DELAY entries.
// ----------------------------------------------------------------------------
module allpass_stereo_decorrelator
  import apsd_pkg::*;
#(
  parameter int MAX_DELAY   = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // left_sample, right_sample
  input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // out_left, out_right
  output logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,
  input  logic                                     cfg_we,
  input  logic [CFG_ADDR_W-1:0]                    cfg_index,
  input  logic [CFG_DATA_W-1:0]                    cfg_data
);

  localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  apsd_cfg_t cfg;
  apsd_cmd_t cmd;
  apsd_sts_t sts;
  logic      clr_req;

  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  assign clr_req = cfg_we && ((cfg_index == REG_LEFT_DELAY_LEN) ||
                              (cfg_index == REG_RIGHT_DELAY_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mix_width       <= MIX_WIDTH_RST;
      cfg.allpass_coeff   <= COEFF_RST;
      cfg.stereo_mode     <= 1'b0;
      cfg.left_delay_len  <= LEFT_LEN_RST;
      cfg.right_delay_len <= RIGHT_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIX_WIDTH:       cfg.mix_width       <= cfg_data;
        REG_ALLPASS_COEFF:   cfg.allpass_coeff   <= $signed(cfg_data);
        REG_STEREO_MODE:     cfg.stereo_mode     <= cfg_data[0];
        REG_LEFT_DELAY_LEN:  cfg.left_delay_len  <= cfg_data[CFG_LEN_W-1:0];
        REG_RIGHT_DELAY_LEN: cfg.right_delay_len <= cfg_data[CFG_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  apsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .clr_req  (clr_req),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  apsd_dp #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .left_sample  ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .right_sample ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .out_left     (out_left),
    .out_right    (out_right)
  );

  assign m_tdata = TDATA_W'({out_right, out_left});

endmodule

// File: tb/allpass_stereo_decorrelator_tb.sv
// ----------------------------------------------------------------------------
// Allpass stereo decorrelator testbench
// Drives audio frames through the stream ports and checks every result
// against a predictor that keeps its own copy of the delay lines and settings.
// A short directed part covers sample extremes, bypassed and oversized delay
// lines, oversized widths, unmapped writes and delay-line clears. Random
// phases with new settings and random stalls on both sides follow.
// ----------------------------------------------------------------------------
module allpass_stereo_decorrelator_tb
  import apsd_pkg::*;
();

  localparam int SAMPLE_W    = 16;
  localparam int STORE_BITS  = SAMPLE_W + 4;
  localparam int LINE_DEPTH  = 256;
  localparam int DATA_W      = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int FRAME_COUNT = 1400;
  localparam int QUIET_FROM  = 1200;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } frame_t;

  class decorrelator_scoreboard;
    logic [CFG_DATA_W-1:0]        mix_width;
    logic signed [CFG_DATA_W-1:0] coeff;
    logic                         stereo;
    logic [CFG_LEN_W-1:0]         left_len;
    logic [CFG_LEN_W-1:0]         right_len;
    longint                       left_line[LINE_DEPTH];
    longint                       right_line[LINE_DEPTH];
    int                           left_ptr;
    int                           right_ptr;
    frame_t                       expected_frames[$];
    int                           errors;

    function new();
      mix_width = MIX_WIDTH_RST;
      coeff = COEFF_RST;
      stereo = 1'b0;
      left_len = LEFT_LEN_RST;
      right_len = RIGHT_LEN_RST;
      errors = 0;
      clear_lines();
    endfunction

    function void clear_lines();
      for (int i = 0; i < LINE_DEPTH; i++) begin
        left_line[i] = 0;
        right_line[i] = 0;
      end
      left_ptr = 0;
      right_ptr = 0;
    endfunction

    function longint q15_round(longint v);
      return (v + Q15_HALF) >>> Q15_FRAC;
    endfunction

    function longint clamp(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void apply_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_MIX_WIDTH: mix_width = value;
        REG_ALLPASS_COEFF: coeff = value;
        REG_STEREO_MODE: stereo = value[0];
        REG_LEFT_DELAY_LEN: begin
          left_len = value[CFG_LEN_W-1:0];
          clear_lines();
        end
        REG_RIGHT_DELAY_LEN: begin
          right_len = value[CFG_LEN_W-1:0];
          clear_lines();
        end
        default: ;
      endcase
    endfunction

    // One allpass section; lane 0 is the left line, lane 1 the right line.
    function longint run_allpass(longint x, bit lane);
      longint d, y, stored;
      int len, p;
      len = lane ? int'(right_len) : int'(left_len);
      if (len > LINE_DEPTH) len = LINE_DEPTH;
      if (len == 0) return x;
      p = lane ? right_ptr : left_ptr;
      if (p >= len) p = 0;
      d = lane ? right_line[p] : left_line[p];
      y = clamp(d - q15_round(longint'(coeff) * x), STORE_BITS);
      stored = clamp(x + q15_round(longint'(coeff) * y), STORE_BITS);
      if (lane) right_line[p] = stored;
      else left_line[p] = stored;
      p = (p + 1 == len) ? 0 : p + 1;
      if (lane) right_ptr = p;
      else left_ptr = p;
      return y;
    endfunction

    function void note_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      longint w, x, mid, yl, yr, ol, orr;
      frame_t f;
      w = (mix_width > Q15_ONE) ? longint'(Q15_ONE) : longint'(mix_width);
      if (stereo) begin
        mid = (longint'(l) + longint'(r)) >>> 1;
        x = (longint'(l) - longint'(r)) >>> 1;
      end else begin
        mid = 0;
        x = longint'(l);
      end
      yl = run_allpass(x, 1'b0);
      yr = run_allpass(x, 1'b1);
      yl = q15_round(x * (Q15_ONE - w) + yl * w);
      yr = q15_round(x * (Q15_ONE - w) + yr * w);
      ol = stereo ? mid + yl : yl;
      orr = stereo ? mid - yr : yr;
      f.left = SAMPLE_W'(clamp(ol, SAMPLE_W));
      f.right = SAMPLE_W'(clamp(orr, SAMPLE_W));
      expected_frames.push_back(f);
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, got left %0d right %0d", $time, got.left,
                 got.right);
        return;
      end
      want = expected_frames.pop_front();
      if (got.left !== want.left) begin
        errors++;
        $display("%0t: out_left expected %0d actual %0d", $time, want.left, got.left);
      end
      if (got.right !== want.right) begin
        errors++;
        $display("%0t: out_right expected %0d actual %0d", $time, want.right, got.right);
      end
    endfunction

    function int pending_count();
      return expected_frames.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [DATA_W-1:0]     m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  decorrelator_scoreboard sb = new();
  bit          idle_on = 1'b0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  int          frames_sent = 0;

  allpass_stereo_decorrelator #(
    .MAX_DELAY  (LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("allpass_stereo_decorrelator_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_frame(frame_t'(m_tdata[2*SAMPLE_W-1:0]));
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.apply_write(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DATA_W'({r, l});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_frame(l, r);
    frames_sent++;
    @(negedge clk);
  endtask

  // Ends a phase: no request pending, every result back, pipeline empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [CFG_LEN_W-1:0] pick_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) return '0;
    if (sel < 13) return CFG_LEN_W'($urandom_range(1, 12));
    if (sel < 18) return CFG_LEN_W'($urandom_range(13, LINE_DEPTH));
    return CFG_LEN_W'($urandom_range(LINE_DEPTH + 1, (1 << CFG_LEN_W) - 1));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    if (sel < 3) return SAMPLE_W'($urandom_range(0, 64) - 32);
    return SAMPLE_W'($urandom);
  endfunction

  initial begin
    int n, sel;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: mono and dry; the right sample must have no effect.
    send_frame(32767, 0);
    send_frame(-32768, 0);
    send_frame(0, 32767);
    send_frame(-1, -32768);
    send_frame(1, 1);
    send_frame(0, 0);
    drain();

    // Stereo, fully wet, strongest positive feedback, very short lines.
    write_reg(REG_MIX_WIDTH, 16'd32768);
    write_reg(REG_ALLPASS_COEFF, 16'h7fff);
    write_reg(REG_STEREO_MODE, 16'd1);
    write_reg(REG_LEFT_DELAY_LEN, 16'd1);
    write_reg(REG_RIGHT_DELAY_LEN, 16'd2);
    send_frame(32767, 32767);
    send_frame(-32768, -32768);
    send_frame(32767, -32768);
    send_frame(-32768, 32767);
    send_frame(-1, 0);
    send_frame(0, -1);
    send_frame(12345, -12345);
    send_frame(0, 0);
    drain();

    // Oversized width, most negative feedback, bypassed left line,
    // oversized right line, and writes outside the register map.
    write_reg(REG_STEREO_MODE, 16'd0);
    write_reg(REG_ALLPASS_COEFF, 16'h8000);
    write_reg(REG_MIX_WIDTH, 16'hffff);
    write_reg(REG_LEFT_DELAY_LEN, 16'd0);
    write_reg(REG_RIGHT_DELAY_LEN, 16'd511);
    for (int k = int'(REG_RIGHT_DELAY_LEN) + 1; k < (1 << CFG_ADDR_W); k++)
      write_reg(CFG_ADDR_W'(k), CFG_DATA_W'($urandom));
    send_frame(32767, 0);
    send_frame(-32768, 0);
    send_frame(-32768, 0);
    send_frame(32767, 0);
    send_frame(100, 0);
    send_frame(-100, 0);
    drain();

    // Rewriting an unchanged delay length still clears both lines.
    write_reg(REG_RIGHT_DELAY_LEN, 16'd511);
    send_frame(-32768, 0);
    send_frame(32767, 0);
    send_frame(-7, 0);
    send_frame(7, 0);
    drain();

    while (frames_sent < FRAME_COUNT) begin
      idle_on = (frames_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        sel = $urandom_range(0, 3);
        write_reg(REG_MIX_WIDTH, (sel == 0) ? 16'd0 : (sel == 1) ? 16'd32768 :
                  (sel == 2) ? CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 32768)));
      end
      if ($urandom_range(0, 1)) begin
        sel = $urandom_range(0, 5);
        write_reg(REG_ALLPASS_COEFF, (sel == 0) ? 16'h7fff : (sel == 1) ? 16'h8000 :
                  CFG_DATA_W'($urandom));
      end
      if ($urandom_range(0, 1))
        write_reg(REG_STEREO_MODE, CFG_DATA_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_LEFT_DELAY_LEN, CFG_DATA_W'(pick_len()));
      if ($urandom_range(0, 2) == 0) write_reg(REG_RIGHT_DELAY_LEN, CFG_DATA_W'(pick_len()));
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_ADDR_W'($urandom_range(int'(REG_RIGHT_DELAY_LEN) + 1,
                                             (1 << CFG_ADDR_W) - 1)),
                  CFG_DATA_W'($urandom));
      n = $urandom_range(10, 80);
      for (int i = 0; i < n; i++) send_frame(pick_sample(), pick_sample());
      drain();
    end

    if (sb.pending_count() != 0)
      $display("%0t: %0d results never arrived", $time, sb.pending_count());
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("allpass_stereo_decorrelator_tb: clean");
    end else begin
      $display("allpass_stereo_decorrelator_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/apsd_pkg.sv
src/apsd_ram.sv
src/apsd_ctrl.sv
src/apsd_dp.sv
src/allpass_stereo_decorrelator.sv
tb/allpass_stereo_decorrelator_tb.sv
